// ----- hdl/wall_follow_navigator_assert.svh -----
// assertion macros for the wall-follow navigator rtl
// no dependencies; included by the modules that carry assertions
`ifndef WALL_FOLLOW_NAVIGATOR_ASSERT_SVH
`define WALL_FOLLOW_NAVIGATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// general property, checked outside reset
`define WFN_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wall follow navigator assertion failed");

// same-cycle implication, checked outside reset
`define WFN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wall follow navigator assertion failed");

`else

`define WFN_ASSERT(label, clk, rst_n, prop)
`define WFN_ASSERT_IMP(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/wfn_pkg.sv -----
// shared types, constants and the sine table builder for the navigator
// no dependencies; imported by every module of the block but wfn_fifo
package wfn_pkg;

  localparam int unsigned DIST_W     = 16;
  localparam int unsigned HEADING_W  = 16;
  localparam int unsigned MARKER_W   = 10;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned FRAMES_W   = 4;
  localparam int unsigned STEP_W     = 9;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TRIG_W     = 15;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_WALL   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    MAN_NORMAL = 2'd0,
    MAN_CLEAR  = 2'd1,
    MAN_TURN   = 2'd2,
    MAN_SETTLE = 2'd3
  } maneuver_e;

  typedef enum logic [1:0] {
    ITEM_FRAME      = 2'd0,
    ITEM_SEL_MANUAL = 2'd1,
    ITEM_SEL_WALL   = 2'd2,
    ITEM_IGNORE     = 2'd3
  } item_kind_e;

  typedef enum logic [2:0] {
    KEY_NONE  = 3'd0,
    KEY_UP    = 3'd1,
    KEY_DOWN  = 3'd2,
    KEY_LEFT  = 3'd3,
    KEY_RIGHT = 3'd4
  } key_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED         = 3'd0,
    REG_SEARCH_DIST   = 3'd1,
    REG_SAFE_DIST     = 3'd2,
    REG_LOST_DIST     = 3'd3,
    REG_CLEAR_FRAMES  = 3'd4,
    REG_SETTLE_FRAMES = 3'd5
  } cfg_reg_e;

  localparam logic [MARKER_W-1:0] MARKER_MANUAL = 10'd0;
  localparam logic [MARKER_W-1:0] MARKER_WALL   = 10'd1;

  localparam logic [KEY_W-1:0] KEY_Z_LO = 8'h7a;
  localparam logic [KEY_W-1:0] KEY_Z_UP = 8'h5a;
  localparam logic [KEY_W-1:0] KEY_S_LO = 8'h73;
  localparam logic [KEY_W-1:0] KEY_S_UP = 8'h53;
  localparam logic [KEY_W-1:0] KEY_Q_LO = 8'h71;
  localparam logic [KEY_W-1:0] KEY_Q_UP = 8'h51;
  localparam logic [KEY_W-1:0] KEY_D_LO = 8'h64;
  localparam logic [KEY_W-1:0] KEY_D_UP = 8'h44;

  localparam longint unsigned POLY_A = 64'd102917;
  localparam longint unsigned POLY_B = 64'd42120;
  localparam longint unsigned POLY_C = 64'd4745;
  localparam longint unsigned TRIG_MAX = 64'd32767;

  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    logic [DIST_W-1:0]   search_dist;
    logic [DIST_W-1:0]   safe_dist;
    logic [DIST_W-1:0]   lost_dist;
    logic [FRAMES_W-1:0] clear_frames;
    logic [FRAMES_W-1:0] settle_frames;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    speed:         8'd4,
    search_dist:   16'd160,
    safe_dist:     16'd112,
    lost_dist:     16'd144,
    clear_frames:  4'd5,
    settle_frames: 4'd8
  };

  typedef struct packed {
    item_kind_e        kind;
    key_e              key;
    logic              near_search;
    logic              near_safe;
    logic              wall_lost;
    logic              explored;
    logic              sin_neg;
    logic [TRIG_W-1:0] sin_mag;
    logic              cos_neg;
    logic [TRIG_W-1:0] cos_mag;
  } item_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic [MODE_W-1:0]        mode;
    logic                     done;
  } result_t;

  // quarter-wave sine magnitude in q1.15 for a phase within the first quarter
  function automatic int unsigned sin_mag_q15(input int unsigned f);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned inner;
    longint unsigned mid;
    longint unsigned r;
    t     = longint'(f) << 2;
    t2    = (t * t) >> 16;
    inner = POLY_B - ((t2 * POLY_C) >> 16);
    mid   = POLY_A - ((t2 * inner) >> 16);
    r     = (t * mid) >> 17;
    if (r > TRIG_MAX) begin
      r = TRIG_MAX;
    end
    return int'(r);
  endfunction

endpackage

// ----- hdl/wall_follow_navigator.sv -----
// Wall-follow navigator: marker items pick manual or wall-follow mode and
// frame ticks yield one motion step each. An item is taken on every clock
// while the input queue has room; it passes the item queue and its result
// the result queue, so one result per cycle is kept up as long as results
// are popped. The figure is set by the back stage, which updates the mode
// and maneuver state for one item per cycle while the result queue has
// room; a two-entry queue parts the classifying front from that stage and a
// two-entry result queue parts it from the consumer. Sine and cosine come
// from a constant quarter-wave table of 2**(TRIG_TABLE_BITS-2)+1 entries.
// There is no clearing pass after reset. Register writes take effect on
// the next cycle and are meant to happen while the block is idle.
// depends on wfn_pkg, wfn_front, wfn_fifo and wfn_back
module wall_follow_navigator #(
  parameter int unsigned TRIG_TABLE_BITS = 10,
  parameter int unsigned DIST_BITS       = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [wfn_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [wfn_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  action_i,
  input  logic [wfn_pkg::MARKER_W-1:0]          marker_id_i,
  input  logic [wfn_pkg::KEY_W-1:0]             key_code_i,
  input  logic [wfn_pkg::DIST_W-1:0]            front_distance_i,
  input  logic [wfn_pkg::DIST_W-1:0]            right_distance_i,
  input  logic [wfn_pkg::HEADING_W-1:0]         heading_i,
  input  logic                                  map_explored_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [wfn_pkg::STEP_W-1:0]     step_x_o,
  output logic signed [wfn_pkg::STEP_W-1:0]     step_y_o,
  output logic [wfn_pkg::MODE_W-1:0]            mode_o,
  output logic                                  exploration_done_o
);

  import wfn_pkg::*;

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(result_t);

  cfg_t    cfg_q, cfg_d;
  item_t   front_item, queued_item;
  result_t back_res, out_res;
  logic    item_empty, item_pop;
  logic    res_push, res_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPEED:         cfg_d.speed         = cfg_wdata_i[SPEED_W-1:0];
        REG_SEARCH_DIST:   cfg_d.search_dist   = cfg_wdata_i[DIST_W-1:0];
        REG_SAFE_DIST:     cfg_d.safe_dist     = cfg_wdata_i[DIST_W-1:0];
        REG_LOST_DIST:     cfg_d.lost_dist     = cfg_wdata_i[DIST_W-1:0];
        REG_CLEAR_FRAMES:  cfg_d.clear_frames  = cfg_wdata_i[FRAMES_W-1:0];
        REG_SETTLE_FRAMES: cfg_d.settle_frames = cfg_wdata_i[FRAMES_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wfn_front #(
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
    .DIST_BITS       (DIST_BITS)
  ) u_front (
    .action_i         (action_i),
    .marker_id_i      (marker_id_i),
    .key_code_i       (key_code_i),
    .front_distance_i (front_distance_i),
    .right_distance_i (right_distance_i),
    .heading_i        (heading_i),
    .map_explored_i   (map_explored_i),
    .cfg_i            (cfg_q),
    .item_o           (front_item)
  );

  wfn_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_item_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (item_pop),
    .rdata_o (queued_item),
    .empty_o (item_empty)
  );

  wfn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (queued_item),
    .item_valid_i (!item_empty),
    .item_pop_o   (item_pop),
    .res_o        (back_res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  wfn_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign step_x_o           = out_res.step_x;
  assign step_y_o           = out_res.step_y;
  assign mode_o             = out_res.mode;
  assign exploration_done_o = out_res.done;

endmodule

// ----- hdl/wfn_fifo.sv -----
// small first-in first-out queue used between the front and back stages
// and as the result buffer; depends on wall_follow_navigator_assert.svh
`include "wall_follow_navigator_assert.svh"

module wfn_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `WFN_ASSERT_IMP(a_no_push_when_full, clk_i, rst_ni, push_i, !full_o)
  `WFN_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))

endmodule

// ----- hdl/wfn_front.sv -----
// front stage: classifies each item, decodes keys, compares distances
// and looks up sine and cosine; depends on wfn_pkg
module wfn_front #(
  parameter int unsigned TRIG_TABLE_BITS = 10,
  parameter int unsigned DIST_BITS       = 16
) (
  input  logic                             action_i,
  input  logic [wfn_pkg::MARKER_W-1:0]     marker_id_i,
  input  logic [wfn_pkg::KEY_W-1:0]        key_code_i,
  input  logic [wfn_pkg::DIST_W-1:0]       front_distance_i,
  input  logic [wfn_pkg::DIST_W-1:0]       right_distance_i,
  input  logic [wfn_pkg::HEADING_W-1:0]    heading_i,
  input  logic                             map_explored_i,
  input  wfn_pkg::cfg_t                    cfg_i,
  output wfn_pkg::item_t                   item_o
);

  import wfn_pkg::*;

  localparam int unsigned TB        = TRIG_TABLE_BITS;
  localparam int unsigned IDX_W     = TB - 1;
  localparam int unsigned FRAC_W    = TB - 2;
  localparam int unsigned ROM_DEPTH = (1 << FRAC_W) + 1;
  localparam int unsigned SHIFT     = HEADING_W - TB;
  localparam int unsigned CMP_W     = (DIST_BITS < DIST_W) ? DIST_BITS : DIST_W;
  localparam logic [IDX_W-1:0] QUARTER = IDX_W'(1 << FRAC_W);

  logic [TRIG_W-1:0] sin_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [TRIG_W-1:0] ENTRY = TRIG_W'(sin_mag_q15(g << SHIFT));
    assign sin_rom[g] = ENTRY;
  end

  logic [TB-1:0]     phase;
  logic [1:0]        sin_quad, cos_quad;
  logic [FRAC_W-1:0] frac;
  logic [IDX_W-1:0]  sin_idx, cos_idx;
  key_e              key;
  item_kind_e        kind;

  assign phase    = heading_i[HEADING_W-1 -: TB];
  assign sin_quad = phase[TB-1 -: 2];
  assign cos_quad = sin_quad + 2'd1;
  assign frac     = phase[FRAC_W-1:0];

  // odd quadrants run the quarter wave backwards
  assign sin_idx = sin_quad[0] ? (QUARTER - {1'b0, frac}) : {1'b0, frac};
  assign cos_idx = cos_quad[0] ? (QUARTER - {1'b0, frac}) : {1'b0, frac};

  always_comb begin
    unique case (key_code_i) inside
      KEY_Z_LO, KEY_Z_UP: key = KEY_UP;
      KEY_S_LO, KEY_S_UP: key = KEY_DOWN;
      KEY_Q_LO, KEY_Q_UP: key = KEY_LEFT;
      KEY_D_LO, KEY_D_UP: key = KEY_RIGHT;
      default:            key = KEY_NONE;
    endcase
  end

  always_comb begin
    if (!action_i) begin
      kind = ITEM_FRAME;
    end else if (marker_id_i == MARKER_MANUAL) begin
      kind = ITEM_SEL_MANUAL;
    end else if (marker_id_i == MARKER_WALL) begin
      kind = ITEM_SEL_WALL;
    end else begin
      kind = ITEM_IGNORE;
    end
  end

  always_comb begin
    item_o.kind        = kind;
    item_o.key         = key;
    item_o.near_search = front_distance_i[CMP_W-1:0] < cfg_i.search_dist[CMP_W-1:0];
    item_o.near_safe   = front_distance_i[CMP_W-1:0] < cfg_i.safe_dist[CMP_W-1:0];
    item_o.wall_lost   = right_distance_i[CMP_W-1:0] > cfg_i.lost_dist[CMP_W-1:0];
    item_o.explored    = map_explored_i;
    item_o.sin_neg     = sin_quad[1];
    item_o.sin_mag     = sin_rom[sin_idx];
    item_o.cos_neg     = cos_quad[1];
    item_o.cos_mag     = sin_rom[cos_idx];
  end

endmodule

// ----- hdl/wfn_back.sv -----
// back stage: mode and wall-following state machine, step scaling
// and result assembly; depends on wfn_pkg and wall_follow_navigator_assert.svh
`include "wall_follow_navigator_assert.svh"

module wfn_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wfn_pkg::cfg_t    cfg_i,
  input  wfn_pkg::item_t   item_i,
  input  logic             item_valid_i,
  output logic             item_pop_o,
  output wfn_pkg::result_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i
);

  import wfn_pkg::*;

  localparam int unsigned PROD_W = SPEED_W + TRIG_W;

  mode_e                    mode_q, mode_d, sel_mode;
  maneuver_e                man_q, man_d;
  logic                     found_q, found_d;
  logic                     done_q, done_d;
  logic [FRAMES_W-1:0]      count_q, count_d, count_inc;
  logic                     fire;
  logic [PROD_W-1:0]        sin_prod, cos_prod;
  logic signed [STEP_W-1:0] sin_step, cos_step, speed_step;
  logic signed [STEP_W-1:0] step_x, step_y;

  assign fire       = item_valid_i && !res_full_i;
  assign item_pop_o = fire;
  assign res_push_o = fire;

  // magnitude times speed, truncated, then sign put back
  assign sin_prod   = PROD_W'(cfg_i.speed) * PROD_W'(item_i.sin_mag);
  assign cos_prod   = PROD_W'(cfg_i.speed) * PROD_W'(item_i.cos_mag);
  assign sin_step   = item_i.sin_neg ? -$signed({1'b0, sin_prod[PROD_W-1:TRIG_W]})
                                     :  $signed({1'b0, sin_prod[PROD_W-1:TRIG_W]});
  assign cos_step   = item_i.cos_neg ? -$signed({1'b0, cos_prod[PROD_W-1:TRIG_W]})
                                     :  $signed({1'b0, cos_prod[PROD_W-1:TRIG_W]});
  assign speed_step = $signed({1'b0, cfg_i.speed});
  assign count_inc  = count_q + 1'b1;

  always_comb begin
    mode_d   = mode_q;
    man_d    = man_q;
    found_d  = found_q;
    done_d   = done_q;
    count_d  = count_q;
    step_x   = '0;
    step_y   = '0;
    sel_mode = (item_i.kind == ITEM_SEL_MANUAL) ? MODE_MANUAL : MODE_WALL;
    if (fire) begin
      unique case (item_i.kind)
        ITEM_SEL_MANUAL, ITEM_SEL_WALL: begin
          if (sel_mode != mode_q) begin
            mode_d  = sel_mode;
            found_d = 1'b0;
            man_d   = MAN_NORMAL;
            count_d = '0;
          end
        end
        ITEM_IGNORE: begin
          mode_d = mode_q;
        end
        ITEM_FRAME: begin
          if (mode_q == MODE_MANUAL) begin
            case (item_i.key)
              KEY_UP:    step_y = -speed_step;
              KEY_DOWN:  step_y = speed_step;
              KEY_LEFT:  step_x = -speed_step;
              KEY_RIGHT: step_x = speed_step;
              default:   step_x = '0;
            endcase
          end else if (mode_q == MODE_WALL) begin
            done_d = done_q || item_i.explored;
            if (!done_d) begin
              if (!found_q) begin
                if (item_i.near_search) begin
                  found_d = 1'b1;
                  step_x  = sin_step;
                  step_y  = -cos_step;
                end else begin
                  step_x = cos_step;
                  step_y = sin_step;
                end
              end else if (item_i.near_safe) begin
                // blocked ahead: turn left and drop any corner sequence
                step_x  = sin_step;
                step_y  = -cos_step;
                man_d   = MAN_NORMAL;
                count_d = '0;
              end else begin
                unique case (man_q)
                  MAN_NORMAL: begin
                    step_x = cos_step;
                    step_y = sin_step;
                    if (item_i.wall_lost) begin
                      man_d   = MAN_CLEAR;
                      count_d = '0;
                    end
                  end
                  MAN_CLEAR: begin
                    step_x  = cos_step;
                    step_y  = sin_step;
                    count_d = count_inc;
                    if (count_inc >= cfg_i.clear_frames) begin
                      man_d = MAN_TURN;
                    end
                  end
                  MAN_TURN: begin
                    step_x  = -sin_step;
                    step_y  = cos_step;
                    man_d   = MAN_SETTLE;
                    count_d = '0;
                  end
                  MAN_SETTLE: begin
                    step_x  = cos_step;
                    step_y  = sin_step;
                    count_d = count_inc;
                    if (count_inc >= cfg_i.settle_frames) begin
                      man_d = MAN_NORMAL;
                    end
                  end
                endcase
              end
            end
          end
        end
      endcase
    end
    res_o.step_x = step_x;
    res_o.step_y = step_y;
    res_o.mode   = mode_d;
    res_o.done   = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      man_q   <= MAN_NORMAL;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      man_q   <= man_d;
      found_q <= found_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  `WFN_ASSERT_IMP(a_no_wall_outside_follow, clk_i, rst_ni, mode_q != MODE_WALL, !found_q)
  `WFN_ASSERT_IMP(a_idle_maneuver_before_wall, clk_i, rst_ni, !found_q, man_q == MAN_NORMAL && count_q == '0)
  `WFN_ASSERT(a_done_sticky, clk_i, rst_ni, done_q |=> done_q)

endmodule

// ----- dv/wall_follow_navigator_test.sv -----
// self-checking testbench for the wall-follow navigator: directed and random
// frame and marker items, per-frame motion predicted and compared in order
// depends on wfn_pkg and the wall_follow_navigator rtl
`timescale 1ns / 1ps

package wfn_test_pkg;
  import wfn_pkg::*;

  localparam int unsigned TRIG_BITS = 10;
  localparam longint unsigned SIN_K1 = 64'd102917;
  localparam longint unsigned SIN_K2 = 64'd42120;
  localparam longint unsigned SIN_K3 = 64'd4745;
  localparam logic [HEADING_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                 action;
    logic [MARKER_W-1:0]  marker_id;
    logic [KEY_W-1:0]     key_code;
    logic [DIST_W-1:0]    front_dist;
    logic [DIST_W-1:0]    right_dist;
    logic [HEADING_W-1:0] heading;
    logic                 explored;
  } nav_item_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic [MODE_W-1:0]        mode;
    logic                     done;
  } nav_step_t;

  // q1.15 sine of a 16-bit phase, quarter-wave polynomial folded by quadrant
  function automatic int sine_q15(input logic [HEADING_W-1:0] phase);
    longint unsigned frac;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned inner;
    longint unsigned mid;
    longint unsigned r;
    frac = phase[13:0];
    if (phase[14]) begin
      frac = 64'd16384 - frac;
    end
    t     = frac << 2;
    t2    = (t * t) >> 16;
    inner = SIN_K2 - ((t2 * SIN_K3) >> 16);
    mid   = SIN_K1 - ((t2 * inner) >> 16);
    r     = (t * mid) >> 17;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return phase[15] ? -int'(r) : int'(r);
  endfunction

  // speed times trig, truncated toward zero
  function automatic int scale_step(input logic [SPEED_W-1:0] spd, input int trig);
    int unsigned mag;
    int          v;
    mag = (trig < 0) ? -trig : trig;
    v   = int'((spd * mag) >> 15);
    return (trig < 0) ? -v : v;
  endfunction

  class nav_scoreboard;
    logic [SPEED_W-1:0]  speed;
    logic [DIST_W-1:0]   search_dist;
    logic [DIST_W-1:0]   safe_dist;
    logic [DIST_W-1:0]   lost_dist;
    logic [FRAMES_W-1:0] clear_frames;
    logic [FRAMES_W-1:0] settle_frames;
    mode_e               mode;
    logic                wall_found;
    maneuver_e           maneuver;
    logic [FRAMES_W-1:0] frame_cnt;
    logic                done;
    nav_step_t           expected_q[$];
    int unsigned         mismatch_cnt;

    function new();
      speed         = CFG_RESET.speed;
      search_dist   = CFG_RESET.search_dist;
      safe_dist     = CFG_RESET.safe_dist;
      lost_dist     = CFG_RESET.lost_dist;
      clear_frames  = CFG_RESET.clear_frames;
      settle_frames = CFG_RESET.settle_frames;
      mode          = MODE_IDLE;
      wall_found    = 1'b0;
      maneuver      = MAN_NORMAL;
      frame_cnt     = '0;
      done          = 1'b0;
      mismatch_cnt  = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SPEED: begin
          speed = data[SPEED_W-1:0];
        end
        REG_SEARCH_DIST: begin
          search_dist = data;
        end
        REG_SAFE_DIST: begin
          safe_dist = data;
        end
        REG_LOST_DIST: begin
          lost_dist = data;
        end
        REG_CLEAR_FRAMES: begin
          clear_frames = data[FRAMES_W-1:0];
        end
        REG_SETTLE_FRAMES: begin
          settle_frames = data[FRAMES_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void follow_wall(input nav_item_t it, output int dx, output int dy);
      logic [HEADING_W-1:0] phase;
      int s;
      int c;
      int fx;
      int fy;
      phase = (it.heading >> (HEADING_W - TRIG_BITS)) << (HEADING_W - TRIG_BITS);
      s  = sine_q15(phase);
      c  = sine_q15(phase + QUARTER_TURN);
      fx = scale_step(speed, c);
      fy = scale_step(speed, s);
      dx = 0;
      dy = 0;
      if (it.explored) begin
        done = 1'b1;
      end
      if (done) begin
        return;
      end
      if (!wall_found) begin
        if (it.front_dist < search_dist) begin
          wall_found = 1'b1;
          dx = scale_step(speed, s);
          dy = -scale_step(speed, c);
        end else begin
          dx = fx;
          dy = fy;
        end
        return;
      end
      // blocked ahead: turn left and drop any corner manoeuvre
      if (it.front_dist < safe_dist) begin
        dx        = scale_step(speed, s);
        dy        = -scale_step(speed, c);
        maneuver  = MAN_NORMAL;
        frame_cnt = '0;
        return;
      end
      case (maneuver)
        MAN_NORMAL: begin
          if (it.right_dist > lost_dist) begin
            maneuver  = MAN_CLEAR;
            frame_cnt = '0;
          end
          dx = fx;
          dy = fy;
        end
        MAN_CLEAR: begin
          dx        = fx;
          dy        = fy;
          frame_cnt = frame_cnt + 1'b1;
          if (frame_cnt >= clear_frames) begin
            maneuver = MAN_TURN;
          end
        end
        MAN_TURN: begin
          dx        = -scale_step(speed, s);
          dy        = scale_step(speed, c);
          maneuver  = MAN_SETTLE;
          frame_cnt = '0;
        end
        default: begin
          dx        = fx;
          dy        = fy;
          frame_cnt = frame_cnt + 1'b1;
          if (frame_cnt >= settle_frames) begin
            maneuver = MAN_NORMAL;
          end
        end
      endcase
    endfunction

    function void note_item(input nav_item_t it);
      nav_step_t r;
      int        dx;
      int        dy;
      mode_e     sel;
      dx = 0;
      dy = 0;
      if (it.action) begin
        if (it.marker_id == MARKER_MANUAL || it.marker_id == MARKER_WALL) begin
          sel = (it.marker_id == MARKER_MANUAL) ? MODE_MANUAL : MODE_WALL;
          if (sel != mode) begin
            mode       = sel;
            wall_found = 1'b0;
            maneuver   = MAN_NORMAL;
            frame_cnt  = '0;
          end
        end
      end else if (mode == MODE_MANUAL) begin
        case (it.key_code)
          KEY_Z_LO, KEY_Z_UP: begin
            dy = -int'(speed);
          end
          KEY_S_LO, KEY_S_UP: begin
            dy = int'(speed);
          end
          KEY_Q_LO, KEY_Q_UP: begin
            dx = -int'(speed);
          end
          KEY_D_LO, KEY_D_UP: begin
            dx = int'(speed);
          end
          default: begin
          end
        endcase
      end else if (mode == MODE_WALL) begin
        follow_wall(it, dx, dy);
      end
      r.step_x = dx[STEP_W-1:0];
      r.step_y = dy[STEP_W-1:0];
      r.mode   = mode;
      r.done   = done;
      expected_q.push_back(r);
    endfunction

    function void check_result(input nav_step_t got);
      nav_step_t want;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: result with none pending: x=%0d y=%0d mode=%0d done=%0b",
                   $time, got.step_x, got.step_y, got.mode, got.done);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.step_x !== want.step_x || got.step_y !== want.step_y ||
          got.mode !== want.mode || got.done !== want.done) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: mismatch: expected x=%0d y=%0d mode=%0d done=%0b, got x=%0d y=%0d mode=%0d done=%0b",
                   $time, want.step_x, want.step_y, want.mode, want.done,
                   got.step_x, got.step_y, got.mode, got.done);
        end
      end
    endfunction
  endclass

endpackage

module wall_follow_navigator_test;
  import wfn_pkg::*;
  import wfn_test_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASES          = 7;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic                  clk_i;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i      = '0;
  logic                  push             = 1'b0;
  logic                  full;
  logic                  action_i         = 1'b0;
  logic [MARKER_W-1:0]   marker_id_i      = '0;
  logic [KEY_W-1:0]      key_code_i       = '0;
  logic [DIST_W-1:0]     front_distance_i = '0;
  logic [DIST_W-1:0]     right_distance_i = '0;
  logic [HEADING_W-1:0]  heading_i        = '0;
  logic                  map_explored_i   = 1'b0;
  logic                  empty;
  logic                  pop              = 1'b0;
  logic signed [STEP_W-1:0] step_x_o;
  logic signed [STEP_W-1:0] step_y_o;
  logic [MODE_W-1:0]     mode_o;
  logic                  exploration_done_o;

  nav_scoreboard     sb            = new();
  int unsigned       send_gap_max  = 19;
  int unsigned       pop_stall_max = 19;
  int unsigned       cycle_cnt     = 0;
  mode_e             stim_mode     = MODE_IDLE;
  logic [DIST_W-1:0] th_search     = CFG_RESET.search_dist;
  logic [DIST_W-1:0] th_safe       = CFG_RESET.safe_dist;
  logic [DIST_W-1:0] th_lost       = CFG_RESET.lost_dist;

  wall_follow_navigator #(
    .TRIG_TABLE_BITS(TRIG_BITS),
    .DIST_BITS      (DIST_W)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push              (push),
    .full              (full),
    .action_i          (action_i),
    .marker_id_i       (marker_id_i),
    .key_code_i        (key_code_i),
    .front_distance_i  (front_distance_i),
    .right_distance_i  (right_distance_i),
    .heading_i         (heading_i),
    .map_explored_i    (map_explored_i),
    .empty             (empty),
    .pop               (pop),
    .step_x_o          (step_x_o),
    .step_y_o          (step_y_o),
    .mode_o            (mode_o),
    .exploration_done_o(exploration_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[wall_follow_navigator] ERROR");
    $finish;
  end

  // register writes, input and result transfers as seen at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        sb.write_reg(cfg_idx_i, cfg_wdata_i);
      end
      if (push && !full) begin
        sb.note_item('{action: action_i, marker_id: marker_id_i, key_code: key_code_i,
                       front_dist: front_distance_i, right_dist: right_distance_i,
                       heading: heading_i, explored: map_explored_i});
      end
      if (pop && !empty) begin
        sb.check_result('{step_x: step_x_o, step_y: step_y_o, mode: mode_o,
                          done: exploration_done_o});
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = $urandom_range(pop_stall_max);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  task automatic send_item(input nav_item_t it);
    int unsigned gap;
    gap = $urandom_range(send_gap_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    action_i         <= it.action;
    marker_id_i      <= it.marker_id;
    key_code_i       <= it.key_code;
    front_distance_i <= it.front_dist;
    right_distance_i <= it.right_dist;
    heading_i        <= it.heading;
    map_explored_i   <= it.explored;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // hold off input until every pending step has been popped
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic nav_item_t make_item(input logic action, input logic [MARKER_W-1:0] id,
                                          input logic [KEY_W-1:0] key,
                                          input logic [DIST_W-1:0] front,
                                          input logic [DIST_W-1:0] right,
                                          input logic [HEADING_W-1:0] heading,
                                          input logic explored);
    nav_item_t it;
    it.action     = action;
    it.marker_id  = id;
    it.key_code   = key;
    it.front_dist = front;
    it.right_dist = right;
    it.heading    = heading;
    it.explored   = explored;
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: return KEY_Z_LO;
      1: return KEY_Z_UP;
      2: return KEY_S_LO;
      3: return KEY_S_UP;
      4: return KEY_Q_LO;
      5: return KEY_Q_UP;
      6: return KEY_D_LO;
      7: return KEY_D_UP;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] dist_below(input logic [DIST_W-1:0] th);
    return (th == '0) ? '0 : DIST_W'($urandom_range(th - 1));
  endfunction

  function automatic logic [DIST_W-1:0] dist_near(input logic [DIST_W-1:0] th);
    case ($urandom_range(3))
      0: return th;
      1: return (th == '0) ? th : th - 1'b1;
      2: return (th == '1) ? th : th + 1'b1;
      default: return DIST_W'($urandom);
    endcase
  endfunction

  // mostly well-formed wall-follow frames, with mode switches and noise
  function automatic nav_item_t random_item(input bit explore_ok);
    nav_item_t   it;
    int unsigned roll;
    it = make_item(1'b0, MARKER_W'($urandom), pick_key(), DIST_W'($urandom),
                   DIST_W'($urandom), HEADING_W'($urandom), 1'($urandom));
    roll = $urandom_range(99);
    if (roll < 2) begin
      it.action    = 1'b1;
      it.marker_id = MARKER_W'($urandom_range(1023, 2));
    end else if (roll < 3) begin
      it.action    = 1'b1;
      it.marker_id = (stim_mode == MODE_MANUAL) ? MARKER_MANUAL : MARKER_WALL;
    end else if ((stim_mode == MODE_WALL && roll < 5) || (stim_mode != MODE_WALL && roll < 15)) begin
      it.action    = 1'b1;
      it.marker_id = (stim_mode == MODE_WALL) ? MARKER_MANUAL : MARKER_WALL;
    end
    if (it.action) begin
      if (it.marker_id == MARKER_MANUAL) begin
        stim_mode = MODE_MANUAL;
      end else if (it.marker_id == MARKER_WALL) begin
        stim_mode = MODE_WALL;
      end
    end else if (stim_mode == MODE_WALL) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        it.front_dist = dist_below(th_safe);
      end else if (roll < 22) begin
        it.front_dist = dist_below(th_search);
      end else if (roll < 32) begin
        it.front_dist = dist_near(roll[0] ? th_search : th_safe);
      end else if (roll < 90) begin
        it.front_dist = DIST_W'($urandom_range(16'hFFFF, th_safe));
      end
      roll = $urandom_range(99);
      if (roll < 30) begin
        it.right_dist = (th_lost == '1) ? th_lost : DIST_W'($urandom_range(16'hFFFF, th_lost + 1));
      end else if (roll < 50) begin
        it.right_dist = dist_near(th_lost);
      end else if (roll < 90) begin
        it.right_dist = DIST_W'($urandom_range(th_lost));
      end
      it.explored = explore_ok && ($urandom_range(29) == 0);
    end
    return it;
  endfunction

  initial begin : stimulus
    logic [SPEED_W-1:0]  spd;
    logic [DIST_W-1:0]   srch;
    logic [DIST_W-1:0]   sf;
    logic [DIST_W-1:0]   lst;
    logic [FRAMES_W-1:0] clr;
    logic [FRAMES_W-1:0] stl;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle frame, ignored marker, manual mode and its keys
    send_item(make_item(1'b0, MARKER_WALL, KEY_Z_LO, 16'h0000, 16'hFFFF, 16'h0000, 1'b1));
    send_item(make_item(1'b1, 10'd1023, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
    send_item(make_item(1'b1, MARKER_MANUAL, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b1, MARKER_MANUAL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(make_item(1'b0, MARKER_WALL, KEY_Z_LO, 16'h1234, 16'h4321, 16'h2AAA, 1'b1));
    send_item(make_item(1'b0, MARKER_WALL, KEY_Z_UP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_WALL, KEY_S_LO, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_WALL, KEY_S_UP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_WALL, KEY_Q_LO, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_WALL, KEY_Q_UP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_WALL, KEY_D_LO, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_WALL, KEY_D_UP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_WALL, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    // wall search, left turns, then an outside corner
    send_item(make_item(1'b1, 10'd2, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b1, MARKER_WALL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
    send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'h0000, 16'hFFFF, 16'h4000, 1'b0));
    send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0));
    for (int i = 0; i < 6; i++) begin
      send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'hFFFF, 16'h0000,
                          HEADING_W'(16'hC000 + i * 16'h0FC1), 1'b0));
    end
    stim_mode = MODE_WALL;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          spd = 8'd255; srch = 16'hFFFF; sf = 16'h0000; lst = 16'h0000; clr = 4'd15; stl = 4'd15;
        end
        1: begin
          spd = 8'd0; srch = 16'h0000; sf = 16'hFFFF; lst = 16'hFFFF; clr = 4'd1; stl = 4'd1;
        end
        2: begin
          spd = 8'd200; srch = 16'd3000; sf = 16'd2000; lst = 16'd2500; clr = 4'd0; stl = 4'd0;
        end
        5: begin
          spd  = CFG_RESET.speed;
          srch = CFG_RESET.search_dist;
          sf   = CFG_RESET.safe_dist;
          lst  = CFG_RESET.lost_dist;
          clr  = CFG_RESET.clear_frames;
          stl  = CFG_RESET.settle_frames;
        end
        default: begin
          spd  = SPEED_W'($urandom);
          srch = DIST_W'($urandom_range(4000));
          sf   = DIST_W'($urandom_range(srch));
          lst  = DIST_W'($urandom_range(4000));
          clr  = FRAMES_W'($urandom_range(15, 1));
          stl  = FRAMES_W'($urandom_range(15, 1));
        end
      endcase
      if (p == 3) begin
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
      end
      write_reg(REG_SPEED, {8'($urandom), spd});
      write_reg(REG_SEARCH_DIST, srch);
      write_reg(REG_SAFE_DIST, sf);
      write_reg(REG_LOST_DIST, lst);
      write_reg(REG_CLEAR_FRAMES, {12'($urandom), clr});
      write_reg(REG_SETTLE_FRAMES, {12'($urandom), stl});
      cfg_we_i  <= 1'b0;
      th_search = srch;
      th_safe   = sf;
      th_lost   = lst;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item(p == PHASES - 1 && n >= ITEMS_PER_PHASE / 2));
      end
    end

    // exploration completion is sticky across frames and mode changes
    send_item(make_item(1'b1, MARKER_WALL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'hFFFF, 16'h0000, 16'h1000, 1'b1));
    send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'hFFFF, 16'hFFFF, 16'h2000, 1'b0));
    send_item(make_item(1'b1, MARKER_MANUAL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_MANUAL, KEY_D_LO, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b1, MARKER_WALL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, MARKER_MANUAL, 8'h00, 16'h0000, 16'hFFFF, 16'h3000, 1'b0));

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatch_cnt == 0) begin
      $display("[wall_follow_navigator] OK");
    end else begin
      $display("[wall_follow_navigator] ERROR");
    end
    $finish;
  end

endmodule
